// ===== rtl/lpsd_pkg.sv =====
package lpsd_pkg;

	localparam int unsigned ByteWidth   = 8;
	localparam int unsigned LenWidth    = 32;
	localparam int unsigned LenBytes    = LenWidth / ByteWidth;
	localparam int unsigned FlagCompBit = 15;
	localparam int unsigned FlagExtBit  = 14;
	localparam int unsigned SizeMsb     = 13;

	typedef struct packed {
		logic [ByteWidth-1:0] payload_byte;
		logic                 is_compressed;
		logic                 first_byte;
		logic                 last_byte;
		logic                 empty_message;
	} result_t;

endpackage

// ===== rtl/length_prefixed_stream_deframer.sv =====
// Length-prefixed stream deframer.
// Input channel (in_valid, in_stall, rx_byte) takes the received stream one
// byte per transaction. Each frame opens with a 16-bit big-endian header:
// bit 15 compressed, bit 14 extended, bits 13..0 size. With the extended bit
// set, a 32-bit big-endian length follows and gives the size instead.
// Output channel (out_valid, out_stall and the result fields) gives one
// transaction per payload byte, tagged with the compressed flag and first/last
// marks; a zero-size frame gives a single transaction with empty_message set.
// Header and length bytes give no output transaction.
// An accepted byte is registered at the input stage, parsed combinationally as
// it moves on, and its result is registered in the output register.
// Throughput: one byte per cycle while the output is not stalled, set by the
// per-byte header/length state update and the 32-bit remaining-count decrement.
// Reset (arst_n low) drops any byte in flight, clears the output register and
// returns the parser to waiting for a header.
// While out_stall is high the result holds; one more byte is buffered at the
// input, then in_stall rises until the output drains.
module length_prefixed_stream_deframer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [lpsd_pkg::ByteWidth-1:0]  rx_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [lpsd_pkg::ByteWidth-1:0]  payload_byte,
	output logic                            is_compressed,
	output logic                            first_byte,
	output logic                            last_byte,
	output logic                            empty_message
);

	logic                           s1_valid;
	logic [lpsd_pkg::ByteWidth-1:0] s1_byte;
	logic                           out_free;
	logic                           consume;
	logic                           has_result;
	lpsd_pkg::result_t              result;

	// advance the registered byte whenever the output register can take it
	assign consume = s1_valid && out_free;

	lpsd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.rx_byte  (rx_byte),
		.in_stall (in_stall),
		.consume  (consume),
		.s1_valid (s1_valid),
		.s1_byte  (s1_byte)
	);

	lpsd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (consume),
		.rx_byte    (s1_byte),
		.has_result (has_result),
		.result     (result)
	);

	lpsd_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (consume && has_result),
		.result        (result),
		.out_free      (out_free),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_byte  (payload_byte),
		.is_compressed (is_compressed),
		.first_byte    (first_byte),
		.last_byte     (last_byte),
		.empty_message (empty_message)
	);

endmodule

// ===== rtl/lpsd_in_stage.sv =====
module lpsd_in_stage (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [lpsd_pkg::ByteWidth-1:0]  rx_byte,
	output logic                            in_stall,
	input  logic                            consume,
	output logic                            s1_valid,
	output logic [lpsd_pkg::ByteWidth-1:0]  s1_byte
);

	logic                           valid_s1;
	logic [lpsd_pkg::ByteWidth-1:0] byte_s1;
	logic                           load;

	assign in_stall = valid_s1 && !consume;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= rx_byte;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_byte  = byte_s1;

endmodule

// ===== rtl/lpsd_parser.sv =====
module lpsd_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fire,
	input  logic [lpsd_pkg::ByteWidth-1:0]  rx_byte,
	output logic                            has_result,
	output lpsd_pkg::result_t               result
);

	localparam logic [1:0] PH_HDR_HI  = 2'd0;
	localparam logic [1:0] PH_HDR_LO  = 2'd1;
	localparam logic [1:0] PH_EXTLEN  = 2'd2;
	localparam logic [1:0] PH_PAYLOAD = 2'd3;

	localparam int unsigned BW  = lpsd_pkg::ByteWidth;
	localparam int unsigned LW  = lpsd_pkg::LenWidth;
	localparam logic [1:0] LAST_LEN_IDX = 2'(lpsd_pkg::LenBytes - 1);

	logic [1:0]       phase_q, phase_d;
	logic [BW-1:0]    hdr_hi_q, hdr_hi_d;
	logic [1:0]       len_idx_q, len_idx_d;
	logic [LW-BW-1:0] ext_len_q, ext_len_d;
	logic [LW-1:0]    rem_q, rem_d;
	logic             seen_first_q, seen_first_d;

	logic [2*BW-1:0]  hdr_word;
	logic [LW-1:0]    full_len;
	logic [LW-1:0]    rem_dec;
	logic [LW-1:0]    size;
	logic             start;

	always_comb begin
		phase_d      = phase_q;
		hdr_hi_d     = hdr_hi_q;
		len_idx_d    = len_idx_q;
		ext_len_d    = ext_len_q;
		rem_d        = rem_q;
		seen_first_d = seen_first_q;
		hdr_word     = {hdr_hi_q, rx_byte};
		full_len     = {ext_len_q, rx_byte};
		rem_dec      = rem_q - LW'(1);
		size         = '0;
		start        = 1'b0;
		has_result   = 1'b0;
		result               = '0;
		result.is_compressed = hdr_hi_q[lpsd_pkg::FlagCompBit - BW];

		case (phase_q)
			PH_HDR_HI: begin
				hdr_hi_d = rx_byte;
				phase_d  = PH_HDR_LO;
			end
			PH_HDR_LO: begin
				if (hdr_word[lpsd_pkg::FlagExtBit]) begin
					ext_len_d = '0;
					len_idx_d = '0;
					phase_d   = PH_EXTLEN;
				end else begin
					size  = LW'(hdr_word[lpsd_pkg::SizeMsb:0]);
					start = 1'b1;
				end
			end
			PH_EXTLEN: begin
				// shift in big-endian, oldest byte falls off the top
				ext_len_d = full_len[LW-BW-1:0];
				if (len_idx_q == LAST_LEN_IDX) begin
					len_idx_d = '0;
					size      = full_len;
					start     = 1'b1;
				end else begin
					len_idx_d = len_idx_q + 2'd1;
				end
			end
			PH_PAYLOAD: begin
				has_result          = 1'b1;
				result.payload_byte = rx_byte;
				result.first_byte   = !seen_first_q;
				result.last_byte    = (rem_dec == '0);
				seen_first_d        = 1'b1;
				rem_d               = rem_dec;
				if (rem_dec == '0) begin
					phase_d = PH_HDR_HI;
				end
			end
			default: begin
				phase_d = PH_HDR_HI;
			end
		endcase

		if (start) begin
			if (size == '0) begin
				// empty frame: one marker transaction, back to header
				has_result           = 1'b1;
				result.payload_byte  = '0;
				result.first_byte    = 1'b1;
				result.last_byte     = 1'b1;
				result.empty_message = 1'b1;
				phase_d              = PH_HDR_HI;
			end else begin
				rem_d        = size;
				seen_first_d = 1'b0;
				phase_d      = PH_PAYLOAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HDR_HI;
			len_idx_q    <= '0;
			rem_q        <= '0;
			seen_first_q <= 1'b0;
		end else if (fire) begin
			phase_q      <= phase_d;
			len_idx_q    <= len_idx_d;
			rem_q        <= rem_d;
			seen_first_q <= seen_first_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hdr_hi_q  <= hdr_hi_d;
			ext_len_q <= ext_len_d;
		end
	end

endmodule

// ===== rtl/lpsd_out_stage.sv =====
module lpsd_out_stage (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  lpsd_pkg::result_t               result,
	output logic                            out_free,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [lpsd_pkg::ByteWidth-1:0]  payload_byte,
	output logic                            is_compressed,
	output logic                            first_byte,
	output logic                            last_byte,
	output logic                            empty_message
);

	logic              valid_q;
	lpsd_pkg::result_t res_q;

	assign out_free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	// hold the payload while the receiver stalls
	always_ff @(posedge clk) begin
		if (out_free && load) begin
			res_q <= result;
		end
	end

	assign out_valid     = valid_q;
	assign payload_byte  = res_q.payload_byte;
	assign is_compressed = res_q.is_compressed;
	assign first_byte    = res_q.first_byte;
	assign last_byte     = res_q.last_byte;
	assign empty_message = res_q.empty_message;

endmodule

// ===== rtl/lpsd_checker.sv =====
module lpsd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic [lpsd_pkg::ByteWidth-1:0]  rx_byte,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [lpsd_pkg::ByteWidth-1:0]  payload_byte,
	input logic                            is_compressed,
	input logic                            first_byte,
	input logic                            last_byte,
	input logic                            empty_message
);

	logic unused_in;
	assign unused_in = in_valid ^ (^rx_byte);

	// reset clears both channels at once
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_stall)
		else $error("channel active during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_byte)
			&& $stable(first_byte) && $stable(last_byte)
			&& $stable(empty_message) && $stable(is_compressed))
		else $error("stalled output transaction changed");

	a_empty_marks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_message |-> first_byte && last_byte && payload_byte == '0)
		else $error("empty frame transaction badly marked");

	// a non-final byte is followed only by bytes of the same frame
	a_frame_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_byte |=> !out_valid
			|| (!first_byte && !empty_message && is_compressed == $past(is_compressed)))
		else $error("frame broken before its last byte");

endmodule

bind length_prefixed_stream_deframer lpsd_checker u_lpsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.rx_byte       (rx_byte),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.payload_byte  (payload_byte),
	.is_compressed (is_compressed),
	.first_byte    (first_byte),
	.last_byte     (last_byte),
	.empty_message (empty_message)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned IdlePct    = 29;

	typedef enum logic [1:0] {
		AWAIT_HDR_HI,
		AWAIT_HDR_LO,
		COLLECT_LEN,
		PASS_PAYLOAD
	} parse_phase_t;

	logic                           clk           = 1'b0;
	logic                           arst_n        = 1'b1;
	logic                           in_valid      = 1'b0;
	logic                           in_stall;
	logic [lpsd_pkg::ByteWidth-1:0] rx_byte       = '0;
	logic                           out_valid;
	logic                           out_stall     = 1'b0;
	logic [lpsd_pkg::ByteWidth-1:0] payload_byte;
	logic                           is_compressed;
	logic                           first_byte;
	logic                           last_byte;
	logic                           empty_message;

	// predictor state
	parse_phase_t                   parse_phase  = AWAIT_HDR_HI;
	logic [15:0]                    hdr_word     = '0;
	logic [1:0]                     len_idx      = '0;
	logic [lpsd_pkg::LenWidth-1:0]  ext_len      = '0;
	logic [lpsd_pkg::LenWidth-1:0]  remaining    = '0;
	logic                           first_done   = 1'b0;

	lpsd_pkg::result_t              expected_bytes[$];
	int unsigned                    sent_items     = 0;
	int unsigned                    mismatch_count = 0;
	int unsigned                    cycle_count    = 0;
	bit                             idle_on        = 1'b1;
	bit                             stall_on       = 1'b1;

	length_prefixed_stream_deframer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_byte  (payload_byte),
		.is_compressed (is_compressed),
		.first_byte    (first_byte),
		.last_byte     (last_byte),
		.empty_message (empty_message)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= stall_on && ($urandom_range(99) < IdlePct);
	end

	function automatic void open_payload(input logic [lpsd_pkg::LenWidth-1:0] size);
		lpsd_pkg::result_t r;
		if (size == '0) begin
			r.payload_byte  = '0;
			r.is_compressed = hdr_word[lpsd_pkg::FlagCompBit];
			r.first_byte    = 1'b1;
			r.last_byte     = 1'b1;
			r.empty_message = 1'b1;
			expected_bytes.push_back(r);
			parse_phase = AWAIT_HDR_HI;
		end else begin
			remaining   = size;
			first_done  = 1'b0;
			parse_phase = PASS_PAYLOAD;
		end
	endfunction

	function automatic void predict_byte(input logic [lpsd_pkg::ByteWidth-1:0] b);
		lpsd_pkg::result_t r;
		case (parse_phase)
			AWAIT_HDR_HI: begin
				hdr_word    = {b, 8'h00};
				parse_phase = AWAIT_HDR_LO;
			end
			AWAIT_HDR_LO: begin
				hdr_word[7:0] = b;
				if (hdr_word[lpsd_pkg::FlagExtBit]) begin
					ext_len     = '0;
					len_idx     = '0;
					parse_phase = COLLECT_LEN;
				end else begin
					open_payload(lpsd_pkg::LenWidth'(hdr_word[lpsd_pkg::SizeMsb:0]));
				end
			end
			COLLECT_LEN: begin
				ext_len = {ext_len[lpsd_pkg::LenWidth-lpsd_pkg::ByteWidth-1:0], b};
				if (len_idx == 2'(lpsd_pkg::LenBytes - 1)) begin
					len_idx = '0;
					open_payload(ext_len);
				end else begin
					len_idx = len_idx + 2'd1;
				end
			end
			default: begin
				r.payload_byte  = b;
				r.is_compressed = hdr_word[lpsd_pkg::FlagCompBit];
				r.first_byte    = !first_done;
				first_done      = 1'b1;
				remaining       = remaining - 1;
				r.last_byte     = (remaining == '0);
				r.empty_message = 1'b0;
				expected_bytes.push_back(r);
				if (r.last_byte)
					parse_phase = AWAIT_HDR_HI;
			end
		endcase
	endfunction

	// predict on every accepted input, then check every accepted result
	always @(posedge clk) begin
		lpsd_pkg::result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_byte(rx_byte);
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected output transaction: payload_byte %0h", payload_byte);
					mismatch_count++;
				end else begin
					want = expected_bytes.pop_front();
					if (payload_byte !== want.payload_byte) begin
						$error("payload_byte: expected %0h, got %0h",
							want.payload_byte, payload_byte);
						mismatch_count++;
					end
					if (is_compressed !== want.is_compressed) begin
						$error("is_compressed: expected %0b, got %0b",
							want.is_compressed, is_compressed);
						mismatch_count++;
					end
					if (first_byte !== want.first_byte) begin
						$error("first_byte: expected %0b, got %0b",
							want.first_byte, first_byte);
						mismatch_count++;
					end
					if (last_byte !== want.last_byte) begin
						$error("last_byte: expected %0b, got %0b",
							want.last_byte, last_byte);
						mismatch_count++;
					end
					if (empty_message !== want.empty_message) begin
						$error("empty_message: expected %0b, got %0b",
							want.empty_message, empty_message);
						mismatch_count++;
					end
				end
			end
		end
	end

	// called at a falling edge, returns at a falling edge after the transaction
	task automatic send_byte(input logic [lpsd_pkg::ByteWidth-1:0] b);
		while (idle_on && ($urandom_range(99) < IdlePct)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_items++;
		@(negedge clk);
	endtask

	// body may be shorter than len only for a frame left open at the end
	task automatic send_frame(input bit comp, input bit ext,
			input logic [lpsd_pkg::LenWidth-1:0] len, input int unsigned body);
		logic [15:0] hdr;
		hdr = {comp, ext, ext ? 14'($urandom) : len[lpsd_pkg::SizeMsb:0]};
		send_byte(hdr[15:8]);
		send_byte(hdr[7:0]);
		if (ext) begin
			for (int i = lpsd_pkg::LenBytes - 1; i >= 0; i--)
				send_byte(len[i*lpsd_pkg::ByteWidth +: lpsd_pkg::ByteWidth]);
		end
		repeat (body)
			send_byte(8'($urandom));
	endtask

	task automatic test_directed();
		logic [lpsd_pkg::ByteWidth-1:0] seq[$];
		// all-zero header, compressed empty frame
		seq = {8'h00, 8'h00, 8'h80, 8'h00};
		// extended with size bits set but length zero
		seq = {seq, 8'h7F, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
		// compressed extended frame of one byte
		seq = {seq, 8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
		// single-byte frame, then a two-byte compressed frame
		seq = {seq, 8'h00, 8'h01, 8'h00, 8'h80, 8'h02, 8'hFF, 8'h00};
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	task automatic test_random_frames(input int unsigned item_goal);
		int unsigned pick;
		int unsigned size;
		bit          ext;
		while (sent_items < item_goal) begin
			// long stretch with no idling on either side first
			idle_on  = (sent_items >= 350);
			stall_on = (sent_items >= 350);
			ext  = ($urandom_range(99) < 30);
			pick = $urandom_range(99);
			if (pick < 10)
				size = 0;
			else if (pick < 70)
				size = $urandom_range(8, 1);
			else if (pick < 95)
				size = $urandom_range(64, 9);
			else
				size = $urandom_range(300, 65);
			send_frame($urandom_range(1), ext, size, size);
		end
		idle_on  = 1'b1;
		stall_on = 1'b1;
	endtask

	// largest length: counted down far past what the run sends, left open at the end
	task automatic test_open_long_frame();
		send_frame(1'b1, 1'b1, 32'hFFFF_FFFF, 200);
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random_frames(1450);
		test_open_long_frame();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lpsd_pkg.sv
rtl/lpsd_in_stage.sv
rtl/lpsd_parser.sv
rtl/lpsd_out_stage.sv
rtl/length_prefixed_stream_deframer.sv
rtl/lpsd_checker.sv
sim/tb_top.sv
